// ===== rtl/spdp_pkg.sv =====
`default_nettype none
package spdp_pkg;

    // input word: one request
    typedef struct packed {
        logic               req_type;
        logic [15:0]        pt_index;
        logic [15:0]        sweep_len;
        logic [23:0]        magnitude;
        logic signed [15:0] phase;
    } t_in_word;

    // output word: one command byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    typedef logic [3:0] t_pos;

    // byte positions inside one command
    localparam t_pos POS_CHAN = 4'd6;
    localparam t_pos POS_SEP  = 4'd7;
    localparam t_pos POS_HUN  = 4'd8;
    localparam t_pos POS_TEN  = 4'd9;
    localparam t_pos POS_ONE  = 4'd10;
    localparam t_pos POS_LAST = 4'd13;

    // request codes
    localparam logic REQ_BEGIN = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // last step index of the log2 iteration
    localparam logic [4:0] LOG_LAST = 5'd23;

    // controller to datapath
    typedef struct packed {
        logic begin_sweep;
        logic latch;
        logic dec_mult;
        logic count_inc;
        logic log_init;
        logic log_step;
        logic db_mult;
        logic scale;
        logic store_val;
        logic dig1;
        logic dig2;
        logic load_out;
        logic chan;
        t_pos pos;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_point;
        logic send;
        logic hun_need;
        logic ten_need;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/spdp_datapath.sv =====
`default_nettype none
module spdp_datapath #(
    parameter int DISPLAY_POINTS = 320,
    parameter int CURVE_TOP      = 127
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  spdp_pkg::t_in_word   i_in_data,
    input  wire                  i_out_ready,
    input  spdp_pkg::t_cmd       i_cmd,
    output spdp_pkg::t_status    o_status,
    output logic                 o_out_valid,
    output spdp_pkg::t_out_word  o_out_data
);

    localparam int CNT_W = $clog2(DISPLAY_POINTS + 1);
    localparam int PRD_W = CNT_W + 17;

    localparam logic [28:0] E_BASE    = 29'd335544320;   // 20 in Q24
    localparam logic [55:0] DB_STEP   = 56'd101008905;   // 20log10(2) in Q24
    localparam logic [55:0] MAG_LIM   = 56'd40 << 48;
    localparam logic [61:0] MAG_HALF  = 62'd20 << 48;
    localparam logic [61:0] PH_RND    = 62'd23040;
    localparam logic [21:0] MAG_RCP   = 22'd1639;        // 2^13/5 rounded up
    localparam logic [28:0] PH_RCP    = 29'd23302;       // 2^20/45 rounded up
    localparam logic [7:0]  TOP_VAL   = 8'(CURVE_TOP);
    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_SEP  = 8'h2C;
    localparam logic [7:0]  TERM_BYTE = 8'hFF;
    localparam logic [7:0]  CMD_HEAD [6] = '{8'h61, 8'h64, 8'h64, 8'h20, 8'h33, 8'h2C};

    // sweep state
    logic [CNT_W-1:0] r_sent_count;
    logic [15:0]      r_sweep_total;

    // latched request
    logic [15:0]        r_idx;
    logic [15:0]        r_tot;
    logic [23:0]        r_mag;
    logic signed [15:0] r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_count  <= '0;
            r_sweep_total <= '0;
        end else if (i_cmd.begin_sweep) begin
            r_sent_count  <= '0;
            r_sweep_total <= i_in_data.sweep_len;
        end else if (i_cmd.count_inc) begin
            r_sent_count  <= r_sent_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_idx <= i_in_data.pt_index;
            r_tot <= i_in_data.sweep_len;
            r_mag <= i_in_data.magnitude;
            r_ph  <= i_in_data.phase;
        end
    end

    // decimation: count <= (idx+1)*N/total  <=>  count*total <= (idx+1)*N
    logic [15:0]      eff_total;
    logic [PRD_W-1:0] r_prod_a;
    logic [PRD_W-1:0] r_prod_b;
    logic             r_tot_zero;

    assign eff_total = (r_tot != 16'd0) ? r_tot : r_sweep_total;

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec_mult) begin
            r_prod_a   <= PRD_W'(r_sent_count) * PRD_W'(eff_total);
            r_prod_b   <= PRD_W'({1'b0, r_idx} + 17'd1) * PRD_W'(DISPLAY_POINTS);
            r_tot_zero <= (eff_total == 16'd0);
        end
    end

    // log2 by repeated squaring
    logic [4:0]  top;
    logic [30:0] y_init;
    logic [61:0] sq;
    logic [31:0] sq_sh;
    logic [30:0] r_y;
    logic [4:0]  r_top;
    logic [23:0] r_frac;

    always_comb begin
        top = 5'd0;
        for (int i = 1; i < 20; i++) begin
            if (r_mag[i]) top = 5'(i);
        end
    end

    assign y_init = {11'd0, r_mag[19:0]} << (5'd30 - top);
    assign sq     = {31'd0, r_y} * {31'd0, r_y};
    assign sq_sh  = sq[61:30];

    always_ff @(posedge i_clk) begin
        if (i_cmd.log_init) begin
            r_y    <= y_init;
            r_top  <= top;
            r_frac <= '0;
        end else if (i_cmd.log_step) begin
            r_y    <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
            r_frac <= {r_frac[22:0], sq_sh[31]};
        end
    end

    // minus dB in Q48
    logic [28:0] e_val;
    logic [55:0] r_n;

    assign e_val = E_BASE - {r_top, r_frac};

    always_ff @(posedge i_clk) begin
        if (i_cmd.db_mult) begin
            r_n <= {27'd0, e_val} * DB_STEP;
        end
    end

    // scaled numerators
    logic [55:0]        mag_diff;
    logic [61:0]        mag_num;
    logic signed [16:0] p_ext;
    logic signed [16:0] p_wrap;
    logic [16:0]        p_off;
    logic [61:0]        ph_num;

    assign mag_diff = MAG_LIM - r_n;
    assign mag_num  = (r_n >= MAG_LIM) ? 62'd0
                    : ({8'd0, mag_diff[53:0]} * 62'(CURVE_TOP)) + MAG_HALF;

    always_comb begin
        p_ext = 17'(r_ph);
        if (p_ext > 17'sd11520) begin
            p_wrap = p_ext - 17'sd23040;
        end else if (p_ext < -17'sd11520) begin
            p_wrap = p_ext + 17'sd23040;
        end else begin
            p_wrap = p_ext;
        end
        p_off = 17'(p_wrap + 17'sd11520);
    end

    assign ph_num = ({47'd0, p_off[14:0]} * 62'(2 * CURVE_TOP)) + PH_RND;

    // divide by 40*2^48 and 46080: drop the power of two, then
    // multiply by the reciprocal of 5 or 45
    logic [10:0] r_mag_sc;
    logic [13:0] r_ph_sc;
    logic [21:0] mag_prod;
    logic [28:0] ph_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_mag_sc <= mag_num[61:51];
            r_ph_sc  <= ph_num[23:10];
        end
    end

    assign mag_prod = {11'd0, r_mag_sc} * MAG_RCP;
    assign ph_prod  = {15'd0, r_ph_sc} * PH_RCP;

    // curve values
    logic [7:0] mag_quo;
    logic [7:0] ph_quo;
    logic [7:0] mag_cap;
    logic [7:0] ph_cap;
    logic [7:0] r_val [2];

    assign mag_quo = mag_prod[20:13];
    assign ph_quo  = ph_prod[27:20];
    assign mag_cap = (mag_quo > TOP_VAL) ? TOP_VAL : mag_quo;
    assign ph_cap  = (ph_quo > TOP_VAL) ? TOP_VAL : ph_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_val) begin
            if (r_mag <= 24'd1) begin
                r_val[0] <= 8'd0;
            end else if (r_mag[23:20] != 4'd0) begin
                r_val[0] <= TOP_VAL;
            end else begin
                r_val[0] <= mag_cap;
            end
            r_val[1] <= ph_cap;
        end
    end

    // decimal digits, two stages
    logic [4:0] r_q10 [2];
    logic [3:0] r_one [2];
    logic [1:0] r_hun [2];
    logic [3:0] r_ten [2];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            logic [15:0] p1;
            logic [15:0] p2;
            logic [7:0]  d1;
            logic [4:0]  d2;
            p1 = {8'd0, r_val[c]} * 16'd205;
            d1 = r_val[c] - 8'({3'd0, p1[15:11]} * 8'd10);
            p2 = {11'd0, r_q10[c]} * 16'd205;
            d2 = r_q10[c] - 5'({3'd0, p2[12:11]} * 5'd10);
            if (i_cmd.dig1) begin
                r_q10[c] <= p1[15:11];
                r_one[c] <= d1[3:0];
            end
            if (i_cmd.dig2) begin
                r_hun[c] <= p2[12:11];
                r_ten[c] <= d2[3:0];
            end
        end
    end

    // byte select
    logic [7:0] cur_val;
    logic [7:0] emit_byte;

    assign cur_val = r_val[i_cmd.chan];

    always_comb begin
        priority if (i_cmd.pos < spdp_pkg::POS_CHAN) begin
            emit_byte = CMD_HEAD[i_cmd.pos[2:0]];
        end else if (i_cmd.pos == spdp_pkg::POS_CHAN) begin
            emit_byte = CHAR_ZERO + {7'd0, i_cmd.chan};
        end else if (i_cmd.pos == spdp_pkg::POS_SEP) begin
            emit_byte = CHAR_SEP;
        end else if (i_cmd.pos == spdp_pkg::POS_HUN) begin
            emit_byte = CHAR_ZERO + {6'd0, r_hun[i_cmd.chan]};
        end else if (i_cmd.pos == spdp_pkg::POS_TEN) begin
            emit_byte = CHAR_ZERO + {4'd0, r_ten[i_cmd.chan]};
        end else if (i_cmd.pos == spdp_pkg::POS_ONE) begin
            emit_byte = CHAR_ZERO + {4'd0, r_one[i_cmd.chan]};
        end else begin
            emit_byte = TERM_BYTE;
        end
    end

    // output register
    logic r_out_valid;
    spdp_pkg::t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.out_byte  <= emit_byte;
            r_out.last_byte <= i_cmd.chan && (i_cmd.pos == spdp_pkg::POS_LAST);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status
    assign o_status.in_point = (i_in_data.req_type == spdp_pkg::REQ_POINT);
    assign o_status.send     = !r_tot_zero
                             && (r_sent_count < CNT_W'(DISPLAY_POINTS))
                             && (r_prod_a <= r_prod_b);
    assign o_status.hun_need = (cur_val >= 8'd100);
    assign o_status.ten_need = (cur_val >= 8'd10);
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ===== rtl/spdp_ctrl.sv =====
`default_nettype none
module spdp_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  spdp_pkg::t_status  i_status,
    output logic               o_in_ready,
    output spdp_pkg::t_cmd     o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_MULT   = 10'b0000000010,
        ST_DECIDE = 10'b0000000100,
        ST_LOG    = 10'b0000001000,
        ST_DBM    = 10'b0000010000,
        ST_SCALE  = 10'b0000100000,
        ST_STORE  = 10'b0001000000,
        ST_DIG1   = 10'b0010000000,
        ST_DIG2   = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } t_state;

    t_state         r_state, n_state;
    logic [4:0]     r_step, n_step;
    logic           r_chan, n_chan;
    spdp_pkg::t_pos r_pos, n_pos;
    logic           accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_chan  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_chan  <= n_chan;
            r_pos   <= n_pos;
        end
    end

    // sequencing and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_chan  = r_chan;
        n_pos   = r_pos;
        o_cmd   = '0;
        o_cmd.chan = r_chan;
        o_cmd.pos  = r_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.begin_sweep = !i_status.in_point;
                    o_cmd.latch       = i_status.in_point;
                    if (i_status.in_point) n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                o_cmd.dec_mult = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_step = '0;
                n_chan = 1'b0;
                if (i_status.send) begin
                    o_cmd.count_inc = 1'b1;
                    o_cmd.log_init  = 1'b1;
                    n_state = ST_LOG;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOG: begin
                o_cmd.log_step = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == spdp_pkg::LOG_LAST) n_state = ST_DBM;
            end
            ST_DBM: begin
                o_cmd.db_mult = 1'b1;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                o_cmd.store_val = 1'b1;
                n_state = ST_DIG1;
            end
            ST_DIG1: begin
                o_cmd.dig1 = 1'b1;
                n_state = ST_DIG2;
            end
            ST_DIG2: begin
                o_cmd.dig2 = 1'b1;
                n_chan  = 1'b0;
                n_pos   = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (r_pos == spdp_pkg::POS_LAST) begin
                        n_pos = '0;
                        if (r_chan) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_chan = 1'b1;
                        end
                    end else if (r_pos == spdp_pkg::POS_SEP) begin
                        if (i_status.hun_need) begin
                            n_pos = spdp_pkg::POS_HUN;
                        end else if (i_status.ten_need) begin
                            n_pos = spdp_pkg::POS_TEN;
                        end else begin
                            n_pos = spdp_pkg::POS_ONE;
                        end
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/spectrum_point_display_plotter.sv =====
// Spectrum point display plotter.
// Input channel (i_in_valid / o_in_ready / i_in_data): one request word, either a
// begin-sweep word (stores the sweep length, clears the sent count) or a point word.
// Output channel (o_out_valid / i_out_ready / o_out_data): command bytes, one per word,
// with last_byte set on the final byte of a point.
// A point that passes decimation yields two commands "add 3,c,v" each closed by three
// 0xFF bytes: 24 to 28 words. A begin word or a dropped point yields nothing.
// One request is handled at a time. A sent point's computation is dominated by the
// 24 squaring steps of the log2 unit; both scalings use reciprocal multiplication.
// Then one output byte is emitted per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its word and byte emission
// pauses; the last byte may wait in the output register while the next request is taken.
// Synchronous active-low reset clears the sweep state and empties the output register.
`default_nettype none
module spectrum_point_display_plotter #(
    parameter int DISPLAY_POINTS = 320,
    parameter int CURVE_TOP      = 127
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  spdp_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output spdp_pkg::t_out_word  o_out_data
);

    spdp_pkg::t_cmd    cmd;
    spdp_pkg::t_status status;

    // sequencer
    spdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // arithmetic and output register
    spdp_datapath #(
        .DISPLAY_POINTS (DISPLAY_POINTS),
        .CURVE_TOP      (CURVE_TOP)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 320;
    localparam int CTOP = 127;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    spdp_pkg::t_in_word  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    spdp_pkg::t_out_word o_out_data;

    spectrum_point_display_plotter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // plotter state mirror
    int unsigned         sent_pts;
    int unsigned         stored_total;
    spdp_pkg::t_out_word byte_q[$];
    int                  n_fail;
    bit                  calm;
    int                  stall_left = 0;

    // magnitude to curve value via log2 in q24
    function automatic int unsigned curve_mag(logic [23:0] raw);
        int unsigned msb;
        longint unsigned y, l2, e, n, lim, x, v;
        msb = 0;
        if (raw <= 1) return 0;
        if (raw >= 24'h100000) return CTOP;
        for (int i = 1; i < 20; i++) if ((raw >> i) != 0) msb = i;
        y = longint'(raw) << (30 - msb);
        l2 = longint'(msb) << 24;
        for (int i = 0; i < 24; i++) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                l2 |= 64'd1 << (23 - i);
                y >>= 1;
            end
        end
        e = (64'd20 << 24) - l2;
        n = e * 64'd101008905;
        lim = 64'd40 << 48;
        if (n >= lim) return 0;
        x = (lim - n) * CTOP / 40;
        v = (x + (64'd1 << 47)) >> 48;
        if (v > CTOP) v = CTOP;
        return 32'(v);
    endfunction

    // wrapped phase to curve value
    function automatic int unsigned curve_phase(logic signed [15:0] ph);
        int p;
        int unsigned v;
        p = ph;
        while (p > 11520) p -= 23040;
        while (p < -11520) p += 23040;
        v = (2 * (p + 11520) * CTOP + 23040) / 46080;
        if (v > CTOP) v = CTOP;
        return v;
    endfunction

    function automatic void push_cmd(int unsigned chan, int unsigned val);
        string head;
        spdp_pkg::t_out_word w;
        head = "add 3,";
        w.last_byte = 1'b0;
        for (int i = 0; i < 6; i++) begin
            w.out_byte = head[i];
            byte_q.push_back(w);
        end
        w.out_byte = 8'(8'h30 + chan); byte_q.push_back(w);
        w.out_byte = ",";              byte_q.push_back(w);
        if (val >= 100) begin w.out_byte = 8'(8'h30 + (val / 100) % 10); byte_q.push_back(w); end
        if (val >= 10) begin w.out_byte = 8'(8'h30 + (val / 10) % 10); byte_q.push_back(w); end
        w.out_byte = 8'(8'h30 + val % 10); byte_q.push_back(w);
        w.out_byte = 8'hFF;
        repeat (3) byte_q.push_back(w);
    endfunction

    // decimation and command building for one request
    function automatic void plot_request(spdp_pkg::t_in_word w);
        int unsigned tot, tgt;
        if (w.req_type == spdp_pkg::REQ_BEGIN) begin
            sent_pts = 0;
            stored_total = w.sweep_len;
            return;
        end
        if (sent_pts >= NPTS) return;
        tot = (w.sweep_len != 0) ? w.sweep_len : stored_total;
        if (tot == 0) return;
        tgt = (int'(w.pt_index) + 1) * NPTS / tot;
        if (tgt >= NPTS) tgt = NPTS - 1;
        if (sent_pts > tgt) return;
        sent_pts++;
        push_cmd(0, curve_mag(w.magnitude));
        push_cmd(1, curve_phase(w.phase));
        byte_q[$].last_byte = 1'b1;
    endfunction

    // send one word with optional random gap
    task automatic send_word(spdp_pkg::t_in_word w);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_data <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        plot_request(w);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (byte_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    function automatic spdp_pkg::t_in_word mk(logic rt, int idx, int tot, int mag, int ph);
        spdp_pkg::t_in_word w;
        w.req_type = rt;
        w.pt_index = 16'(idx);
        w.sweep_len = 16'(tot);
        w.magnitude = 24'(mag);
        w.phase = 16'(ph);
        return w;
    endfunction

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        spdp_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (byte_q.size() == 0) begin
                $error("unexpected word %h", o_out_data);
                n_fail++;
            end else begin
                exp_w = byte_q.pop_front();
                if (o_out_data.out_byte !== exp_w.out_byte) begin
                    $error("out_byte expected %h actual %h", exp_w.out_byte,
                           o_out_data.out_byte);
                    n_fail++;
                end
                if (o_out_data.last_byte !== exp_w.last_byte) begin
                    $error("last_byte expected %b actual %b", exp_w.last_byte,
                           o_out_data.last_byte);
                    n_fail++;
                end
            end
        end
    end

    // field extremes and special cases
    task automatic test_directed();
        send_word(mk(spdp_pkg::REQ_POINT, 0, 0, 24'h100000, 0));       // no total at all
        send_word(mk(spdp_pkg::REQ_BEGIN, 0, 0, 0, 0));
        send_word(mk(spdp_pkg::REQ_POINT, 5, 0, 24'h80000, 0));        // still zero total
        send_word(mk(spdp_pkg::REQ_BEGIN, 0, 4, 0, 0));
        send_word(mk(spdp_pkg::REQ_POINT, 0, 0, 0, 16'sh7FFF));        // stored total, mag zero
        send_word(mk(spdp_pkg::REQ_POINT, 1, 0, 1, -32768));
        send_word(mk(spdp_pkg::REQ_POINT, 2, 0, 2, 11520));
        send_word(mk(spdp_pkg::REQ_POINT, 3, 0, 24'hFFFFFF, -11520));
        send_word(mk(spdp_pkg::REQ_POINT, 0, 65535, 24'h0FFFFF, 11521));
        send_word(mk(spdp_pkg::REQ_POINT, 65535, 1, 24'h0A3D7, -11521));
        send_word(mk(spdp_pkg::REQ_POINT, 65535, 65535, 24'h19999, 23040));
        send_word(mk(spdp_pkg::REQ_BEGIN, 65535, 65535, 24'hFFFFFF, -1));
        send_word(mk(spdp_pkg::REQ_POINT, 0, 0, 24'h028F5, 64));       // kept at the stored total
        send_word(mk(spdp_pkg::REQ_POINT, 65534, 0, 24'h028F6, -64));
        send_word(mk(spdp_pkg::REQ_POINT, 65535, 0, 24'h555555, 5760));
        drain();
    endtask

    // four sweeps, the first past the point limit, each followed by a drain
    task automatic test_sweeps();
        int unsigned len;
        for (int s = 0; s < 4; s++) begin
            len = (s == 0) ? 360 : $urandom_range(1, 60);
            send_word(mk(spdp_pkg::REQ_BEGIN, 0, len, 0, 0));
            for (int i = 0; i < len + 4; i++)
                send_word(mk(spdp_pkg::REQ_POINT, i, ($urandom_range(0, 7) == 0) ? len : 0,
                             $urandom(), $urandom()));
            drain();
        end
    endtask

    // random noise items
    task automatic test_random();
        spdp_pkg::t_in_word w;
        for (int i = 0; i < 60; i++) begin
            w.req_type = ($urandom_range(0, 9) == 0) ? spdp_pkg::REQ_BEGIN
                                                     : spdp_pkg::REQ_POINT;
            w.pt_index = 16'($urandom());
            w.sweep_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 400))
                                               : 16'($urandom());
            w.magnitude = 24'($urandom());
            w.phase = 16'($urandom());
            send_word(w);
        end
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(mk(spdp_pkg::REQ_POINT, i, 40, $urandom_range(0, 24'h1FFFFF),
                         $urandom()));
        drain();
    endtask

    initial begin
        n_fail = 0;
        calm = 1'b0;
        sent_pts = 0;
        stored_total = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_sweeps();
        test_random();
        if (n_fail == 0 && byte_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
